>>> rtl/modular_power_and_inverse_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular power and inverse block
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_POWER_AND_INVERSE_DEFINES_SVH
`define MODULAR_POWER_AND_INVERSE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold too
`define MPI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpi assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle
`define MPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpi assertion failed");

`endif

>>> rtl/mpi_pkg.sv
// ----------------------------------------------------------------------------
// mpi_pkg
// Widths, reset values and the sequencer state type of the modular power block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpi_pkg;

  // Field widths of the request and result
  localparam int unsigned CMD_WIDTH   = 1;
  localparam int unsigned BASE_WIDTH  = 32;
  localparam int unsigned EXPF_WIDTH  = 64;
  localparam int unsigned RES_WIDTH   = 31;
  localparam int unsigned CFG_WIDTH   = 31;

  // Datapath widths: exponent bits scanned and modulus bits kept
  localparam int unsigned EXP_WIDTH   = 64;
  localparam int unsigned MOD_WIDTH   = 31;

  // Counter widths
  localparam int unsigned MCNT_WIDTH  = $clog2(MOD_WIDTH);
  localparam int unsigned ECNT_WIDTH  = $clog2(EXP_WIDTH);
  localparam int unsigned BCNT_WIDTH  = $clog2(BASE_WIDTH);

  // Modulus after reset
  localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = CFG_WIDTH'(1000000007);

  // Command codes
  localparam logic [CMD_WIDTH-1:0] CMD_POWER   = 1'b0;
  localparam logic [CMD_WIDTH-1:0] CMD_INVERSE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

>>> rtl/modular_power_and_inverse.sv
// Sequence: reduce the base bit by bit, then for each exponent bit square and, where
//   the bit is set, multiply; then post the result. A modulus below two skips straight
//   to posting a zero result.
// Throughput: one request at a time, the next accepted once the result is posted; a
//   stalled result holds the block. Reset: asynchronous, active low; idles, drops
//   valid, modulus 1000000007.
// ----------------------------------------------------------------------------
// modular_power_and_inverse
// Square-and-multiply modular exponentiation with a bit-serial shift-add
// multiplier and a bit-serial base reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_power_and_inverse (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [mpi_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  // request channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [mpi_pkg::CMD_WIDTH-1:0]  command_i,
  input  wire logic [mpi_pkg::BASE_WIDTH-1:0] base_i,
  input  wire logic [mpi_pkg::EXPF_WIDTH-1:0] exponent_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [mpi_pkg::RES_WIDTH-1:0]       result_o
);
  import mpi_pkg::*;

  state_e                  state_q, state_d;
  logic [MOD_WIDTH-1:0]    modulus_q;
  logic [EXP_WIDTH-1:0]    exp_sh_q, exp_sh_d;
  logic [BASE_WIDTH-1:0]   base_sh_q, base_sh_d;
  logic [MOD_WIDTH-1:0]    red_q, red_d;
  logic [MOD_WIDTH-1:0]    base_q, base_d;
  logic [MOD_WIDTH-1:0]    acc_q, acc_d;
  logic [MOD_WIDTH-1:0]    x_sh_q, x_sh_d;
  logic [MOD_WIDTH-1:0]    y_q, y_d;
  logic [MOD_WIDTH-1:0]    p_q, p_d;
  logic [MCNT_WIDTH-1:0]   mcnt_q, mcnt_d;
  logic [ECNT_WIDTH-1:0]   ecnt_q, ecnt_d;
  logic [BCNT_WIDTH-1:0]   bcnt_q, bcnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [RES_WIDTH-1:0]    out_result_q, out_result_d;

  logic                    in_accept;
  logic                    mod_small;
  logic [EXP_WIDTH-1:0]    inv_exp;
  logic [MOD_WIDTH:0]      mod_ext;
  logic [MOD_WIDTH:0]      red_sh, red_next;
  logic [MOD_WIDTH:0]      dbl, dbl_red, sum, sum_red;
  logic [MOD_WIDTH-1:0]    mul_p_next;
  logic                    mul_last, red_last, exp_last, bit_set, out_free;

  // Handshake decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign mod_ext   = {1'b0, modulus_q};
  assign mod_small = (modulus_q < MOD_WIDTH'(2));
  assign inv_exp   = EXP_WIDTH'(modulus_q - MOD_WIDTH'(2));

  assign mul_last = (mcnt_q == '0);
  assign red_last = (bcnt_q == '0);
  assign exp_last = (ecnt_q == '0);
  assign bit_set  = exp_sh_q[EXP_WIDTH-1];

  // Base reduction step: shift in one base bit, subtract the modulus once
  assign red_sh   = {red_q, base_sh_q[BASE_WIDTH-1]};
  assign red_next = (red_sh >= mod_ext) ? (red_sh - mod_ext) : red_sh;

  // Multiplier step: double the partial product, add y on a set x bit
  assign dbl        = {p_q, 1'b0};
  assign dbl_red    = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
  assign sum        = dbl_red + (x_sh_q[MOD_WIDTH-1] ? {1'b0, y_q} : '0);
  assign sum_red    = (sum >= mod_ext) ? (sum - mod_ext) : sum;
  assign mul_p_next = sum_red[MOD_WIDTH-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = mod_small ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_last) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mul_last) begin
          if (bit_set) begin
            state_d = ST_MULT;
          end else if (exp_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_MULT: begin
        if (mul_last) begin
          state_d = exp_last ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    exp_sh_d     = exp_sh_q;
    base_sh_d    = base_sh_q;
    red_d        = red_q;
    base_d       = base_q;
    acc_d        = acc_q;
    x_sh_d       = x_sh_q;
    y_d          = y_q;
    p_d          = p_q;
    mcnt_d       = mcnt_q;
    ecnt_d       = ecnt_q;
    bcnt_d       = bcnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_result_d = out_result_q;

    unique case (state_q)
      ST_IDLE: begin
        // Capture the request
        if (in_accept) begin
          exp_sh_d  = (command_i == CMD_INVERSE) ? inv_exp : exponent_i[EXP_WIDTH-1:0];
          base_sh_d = base_i;
          red_d     = '0;
          bcnt_d    = BCNT_WIDTH'(BASE_WIDTH - 1);
          acc_d     = '0;
        end
      end
      ST_REDUCE: begin
        // Fold one base bit into the residue
        red_d     = red_next[MOD_WIDTH-1:0];
        base_sh_d = base_sh_q << 1;
        bcnt_d    = bcnt_q - BCNT_WIDTH'(1);
        if (red_last) begin
          base_d = red_next[MOD_WIDTH-1:0];
          acc_d  = MOD_WIDTH'(1);
          x_sh_d = MOD_WIDTH'(1);
          y_d    = MOD_WIDTH'(1);
          p_d    = '0;
          mcnt_d = MCNT_WIDTH'(MOD_WIDTH - 1);
          ecnt_d = ECNT_WIDTH'(EXP_WIDTH - 1);
        end
      end
      ST_SQUARE, ST_MULT: begin
        // Advance the multiplier by one bit
        p_d    = mul_p_next;
        x_sh_d = x_sh_q << 1;
        mcnt_d = mcnt_q - MCNT_WIDTH'(1);
        if (mul_last) begin
          acc_d  = mul_p_next;
          p_d    = '0;
          mcnt_d = MCNT_WIDTH'(MOD_WIDTH - 1);
          if ((state_q == ST_SQUARE) && bit_set) begin
            // Multiply by the base for a set exponent bit
            x_sh_d = mul_p_next;
            y_d    = base_q;
          end else if (!exp_last) begin
            // Move on to the next exponent bit
            ecnt_d   = ecnt_q - ECNT_WIDTH'(1);
            exp_sh_d = exp_sh_q << 1;
            x_sh_d   = mul_p_next;
            y_d      = mul_p_next;
          end
        end
      end
      ST_FINISH: begin
        // Post the result once the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_result_d = RES_WIDTH'(acc_q);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= MODULUS_RESET[MOD_WIDTH-1:0];
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i[MOD_WIDTH-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    exp_sh_q     <= exp_sh_d;
    base_sh_q    <= base_sh_d;
    red_q        <= red_d;
    base_q       <= base_d;
    acc_q        <= acc_d;
    x_sh_q       <= x_sh_d;
    y_q          <= y_d;
    p_q          <= p_d;
    mcnt_q       <= mcnt_d;
    ecnt_q       <= ecnt_d;
    bcnt_q       <= bcnt_d;
    out_result_q <= out_result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_result_q;

endmodule

`default_nettype wire

>>> rtl/mpi_checker.sv
// ----------------------------------------------------------------------------
// mpi_checker
// Port-level checks of the modular power block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_power_and_inverse_defines.svh"

module mpi_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mpi_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_o,
  input  wire logic [mpi_pkg::CMD_WIDTH-1:0]  command_i,
  input  wire logic [mpi_pkg::BASE_WIDTH-1:0] base_i,
  input  wire logic [mpi_pkg::EXPF_WIDTH-1:0] exponent_i,
  input  wire logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  input  wire logic [mpi_pkg::RES_WIDTH-1:0]  result_o
);
  import mpi_pkg::*;

  logic [MOD_WIDTH-1:0] shadow_mod_q;
  logic [RES_WIDTH-1:0] shadow_mod_ext;
  logic                 shadow_small;

  // Track the modulus as written on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_mod_q <= MODULUS_RESET[MOD_WIDTH-1:0];
    end else if (cfg_we_i) begin
      shadow_mod_q <= cfg_wdata_i[MOD_WIDTH-1:0];
    end
  end

  assign shadow_mod_ext = RES_WIDTH'(shadow_mod_q);
  assign shadow_small   = (shadow_mod_q < MOD_WIDTH'(2));

  // A result held under stall stays valid and keeps its value
  `MPI_ASSERT_NEXT(a_result_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_o))

  // A stalled request stays offered and keeps its payload
  `MPI_ASSERT_NEXT(a_request_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(command_i) && $stable(base_i) && $stable(exponent_i))

  // An accepted request keeps the block busy on the next cycle
  `MPI_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Every result is a residue of the current modulus
  `MPI_ASSERT_NOW(a_result_range, out_valid_o,
    (result_o < shadow_mod_ext) || (shadow_small && (result_o == '0)))

endmodule

bind modular_power_and_inverse mpi_checker u_mpi_checker (.*);

`default_nettype wire

>>> tb/modular_power_and_inverse_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_power_and_inverse_test
// Drives power and inverse requests through a range of modulus settings,
// predicts every residue with a square-and-multiply model and compares each
// result in order. The request side idles and the result side stalls at random.
// ----------------------------------------------------------------------------

// Predicts residues and checks them in arrival order
class residue_scoreboard;
  bit [mpi_pkg::CFG_WIDTH-1:0] modulus;
  bit [mpi_pkg::RES_WIDTH-1:0] expected_residues[$];
  int errors;

  function new();
    modulus = mpi_pkg::MODULUS_RESET;
    errors  = 0;
  endfunction

  function void set_modulus(bit [mpi_pkg::CFG_WIDTH-1:0] value);
    modulus = value;
  endfunction

  // Scan the exponent from the top bit: square, then multiply where the bit is set
  function bit [mpi_pkg::RES_WIDTH-1:0] mod_power(bit [mpi_pkg::CMD_WIDTH-1:0] cmd,
                                                  bit [mpi_pkg::BASE_WIDTH-1:0] base,
                                                  bit [mpi_pkg::EXPF_WIDTH-1:0] exponent);
    longint unsigned md;
    longint unsigned acc;
    longint unsigned b;
    bit [63:0] e;
    if (modulus < 2) return '0;
    md  = 64'(modulus);
    b   = 64'(base) % md;
    e   = (cmd == mpi_pkg::CMD_INVERSE) ? 64'(md - 2) : 64'(exponent);
    acc = 64'd1;
    for (int i = mpi_pkg::EXP_WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % md;
      if (e[i]) acc = (acc * b) % md;
    end
    return acc[mpi_pkg::RES_WIDTH-1:0];
  endfunction

  function void note_request(bit [mpi_pkg::CMD_WIDTH-1:0] cmd,
                             bit [mpi_pkg::BASE_WIDTH-1:0] base,
                             bit [mpi_pkg::EXPF_WIDTH-1:0] exponent);
    bit [mpi_pkg::RES_WIDTH-1:0] predicted;
    predicted         = mod_power(cmd, base, exponent);
    expected_residues = {expected_residues, predicted};
  endfunction

  function void check_result(bit [mpi_pkg::RES_WIDTH-1:0] actual);
    bit [mpi_pkg::RES_WIDTH-1:0] wanted;
    if (expected_residues.size() == 0) begin
      $display("%0t: unexpected result %0d", $time, actual);
      errors++;
      return;
    end
    wanted = expected_residues.pop_front();
    if (actual !== wanted) begin
      $display("%0t: result mismatch, expected %0d actual %0d", $time, wanted, actual);
      errors++;
    end
  endfunction

  function int pending();
    return expected_residues.size();
  endfunction
endclass

module modular_power_and_inverse_test;
  import mpi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned SETTLE_CYCLES = 4100;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_RUNS,
    STALL_HEAVY
  } stall_mode_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_WIDTH-1:0]   cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [CMD_WIDTH-1:0]   command_i   = CMD_POWER;
  logic [BASE_WIDTH-1:0]  base_i      = '0;
  logic [EXPF_WIDTH-1:0]  exponent_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [RES_WIDTH-1:0]   result_o;

  residue_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  int          mode_left   = 0;
  int          run_left    = 0;
  bit          run_high    = 1'b0;

  modular_power_and_inverse u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Note accepted requests and check accepted results on the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(command_i, base_i, exponent_i);
      if (out_valid_o && !out_stall_i) sb.check_result(result_o);
    end
  end

  // Stall the result side in changing modes
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 3000);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_COIN: out_stall_i <= ($urandom_range(0, 1) == 1);
      STALL_RUNS: begin
        if (run_left == 0) begin
          run_high = !run_high;
          run_left = $urandom_range(1, 40);
        end else begin
          run_left--;
        end
        out_stall_i <= run_high;
      end
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Offer one request, hold it until accepted, then continue the burst or idle
  task automatic send_request(input logic [CMD_WIDTH-1:0] cmd,
                              input logic [BASE_WIDTH-1:0] base,
                              input logic [EXPF_WIDTH-1:0] exponent);
    int gap;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    base_i     <= base;
    exponent_i <= exponent;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 4000) : $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  // Drop valid and wait until every expected residue has come back
  task automatic drain_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Write the modulus while the block is idle
  task automatic write_modulus(input logic [CFG_WIDTH-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_modulus(value);
  endtask

  // Random request with bases and exponents spread over the interesting classes
  task automatic send_random_request();
    logic [CMD_WIDTH-1:0]  cmd;
    logic [BASE_WIDTH-1:0] base;
    logic [EXPF_WIDTH-1:0] exponent;
    longint unsigned       md;
    int                    pick;
    md  = 64'(sb.modulus);
    cmd = ($urandom_range(0, 3) == 0) ? CMD_INVERSE : CMD_POWER;
    pick = $urandom_range(0, 99);
    if (pick < 40)      base = $urandom;
    else if (pick < 60) base = $urandom_range(0, 15);
    else if (pick < 75) base = BASE_WIDTH'(md * $urandom_range(0, 2));
    else if (md >= 2)   base = $urandom_range(0, 32'(md - 1));
    else                base = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40)      exponent = {$urandom, $urandom};
    else if (pick < 60) exponent = EXPF_WIDTH'($urandom_range(0, 8));
    else if (pick < 80) exponent = {$urandom, $urandom} >> $urandom_range(0, 63);
    else if (pick < 85) exponent = '1;
    else if (pick < 90) exponent = 64'd1 << $urandom_range(0, 63);
    else                exponent = '0;
    send_request(cmd, base, exponent);
  endtask

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("modular_power_and_inverse_test NOT OK");
    $finish;
  end

  initial begin
    logic [CFG_WIDTH-1:0] phase_moduli[12];
    int                   count;
    phase_moduli = '{31'd1000000007, 31'd2147483647, 31'd2, 31'd998244353, 31'd0,
                     31'd1000000, 31'd0, 31'd3, 31'd1, 31'd65537, 31'd0,
                     31'd1000000007};
    phase_moduli[6]  = CFG_WIDTH'($urandom);
    phase_moduli[10] = CFG_WIDTH'($urandom_range(2, 5000));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset modulus, field extremes, zero exponent, base multiples
    send_request(CMD_POWER,   32'd0,          64'd0);
    send_request(CMD_POWER,   32'd0,          64'd1);
    send_request(CMD_POWER,   32'hFFFF_FFFF,  64'd0);
    send_request(CMD_POWER,   32'hFFFF_FFFF,  '1);
    send_request(CMD_POWER,   32'd2,          64'd1);
    send_request(CMD_POWER,   32'd1000000007, 64'd12345);
    send_request(CMD_POWER,   32'd2000000014, 64'd3);
    send_request(CMD_POWER,   32'd3,          64'h8000_0000_0000_0000);
    send_request(CMD_POWER,   32'd123456789,  64'd1000000006);
    send_request(CMD_POWER,   32'd1000000006, 64'd2);
    send_request(CMD_INVERSE, 32'd2,          64'd0);
    send_request(CMD_INVERSE, 32'hFFFF_FFFF,  '1);
    send_request(CMD_INVERSE, 32'd0,          64'd5);
    send_request(CMD_INVERSE, 32'd1000000007, 64'd0);
    send_request(CMD_INVERSE, 32'd1,          64'hAAAA_5555_0F0F_F0F0);
    drain_results();

    // Directed: largest modulus
    write_modulus(31'h7FFF_FFFF);
    send_request(CMD_INVERSE, 32'd2147483646, 64'd0);
    send_request(CMD_POWER,   32'hFFFF_FFFF,  '1);
    drain_results();

    // Directed: modulus two turns the inverse exponent into zero
    write_modulus(31'd2);
    send_request(CMD_INVERSE, 32'd5, 64'd0);
    send_request(CMD_POWER,   32'd3, 64'd0);
    drain_results();

    // Directed: modulus below two answers zero
    write_modulus(31'd0);
    send_request(CMD_POWER,   32'd7, 64'd0);
    drain_results();
    write_modulus(31'd1);
    send_request(CMD_INVERSE, 32'd7, 64'd9);
    drain_results();

    // Directed: inverse under a composite modulus is computed as written
    write_modulus(31'd1000000);
    send_request(CMD_INVERSE, 32'd7, 64'd0);
    send_request(CMD_INVERSE, 32'd10, 64'd0);
    drain_results();

    // Random phases, one modulus each, with occasional full drains mid-phase
    foreach (phase_moduli[p]) begin
      write_modulus(phase_moduli[p]);
      count = $urandom_range(7, 13);
      repeat (count) begin
        send_random_request();
        if ($urandom_range(0, 9) == 0) drain_results();
      end
      drain_results();
    end

    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("modular_power_and_inverse_test OK");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d expected results never came", $time,
                                      sb.pending());
      $display("modular_power_and_inverse_test NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mpi_pkg.sv
rtl/modular_power_and_inverse.sv
rtl/mpi_checker.sv
tb/modular_power_and_inverse_test.sv
